FILE: sv/hla_pkg.sv
// Shared types and defaults for the hyperperiod LCM accumulator.
package hla_pkg;

    localparam int PERIOD_WIDTH_DEF = 32;
    localparam int ACC_WIDTH_DEF    = 64;

    // How the pending transaction is resolved at write-back
    typedef enum logic [1:0] {
        K_ZERO = 2'd0,   // zero period, state untouched
        K_SAT  = 2'd1,   // already saturated, stays at all ones
        K_MUL  = 2'd2    // full gcd / divide / multiply result
    } t_kind;

    typedef struct packed {
        logic  load;      // take the input transaction, apply restart
        logic  gcd_step;
        logic  div_load;
        logic  div_step;
        logic  mul_step;
        logic  commit;    // update state and fill the output register
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic zero_in;    // incoming period is zero
        logic sat_in;     // overflow already seen (after restart)
        logic gcd_done;
    } t_sts;

endpackage

FILE: sv/hla_datapath.sv
// Datapath: binary gcd, restoring divider, shift-add multiplier, state and output registers.
module hla_datapath #(
    parameter int PW = hla_pkg::PERIOD_WIDTH_DEF,
    parameter int AW = hla_pkg::ACC_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [PW-1:0]   i_period,
    input  logic            i_restart,
    input  hla_pkg::t_cmd   i_cmd,
    output hla_pkg::t_sts   o_sts,
    output logic [AW-1:0]   o_running_lcm,
    output logic            o_overflowed,
    output logic            o_zero_period
);

    localparam int GW = (AW > PW) ? AW : PW;

    logic [AW-1:0]    r_acc;
    logic             r_ovf;
    logic [GW-1:0]    r_x;
    logic [GW-1:0]    r_y;
    logic [AW-1:0]    r_ash;     // running value with common factors of two removed
    logic [AW-1:0]    r_q;
    logic [AW-1:0]    r_rem;
    logic [AW+PW-1:0] r_prod;
    logic [AW-1:0]    r_out_lcm;
    logic             r_out_ovf;
    logic             r_out_zero;

    logic [AW-1:0]    a_eff;
    logic [GW-1:0]    n_x;
    logic [GW-1:0]    n_y;
    logic [AW-1:0]    n_ash;
    logic [AW:0]      div_t;
    logic [AW:0]      div_d;
    logic [AW:0]      div_diff;
    logic             div_ge;
    logic [AW:0]      mul_sum;
    logic             prod_ovf;

    assign a_eff = i_restart ? AW'(1) : r_acc;

    assign o_sts.zero_in  = (i_period == '0);
    assign o_sts.sat_in   = !i_restart && r_ovf;
    assign o_sts.gcd_done = (r_x == r_y);

    // One Stein step; odd-odd case subtracts and halves in the same cycle
    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_ash = r_ash;
        if (!r_x[0] && !r_y[0]) begin
            n_x   = r_x >> 1;
            n_y   = r_y >> 1;
            n_ash = r_ash >> 1;
        end else if (!r_x[0]) begin
            n_x = r_x >> 1;
        end else if (!r_y[0]) begin
            n_y = r_y >> 1;
        end else if (r_x >= r_y) begin
            n_x = (r_x - r_y) >> 1;
        end else begin
            n_y = (r_y - r_x) >> 1;
        end
    end

    assign div_t    = {r_rem, r_q[AW-1]};
    assign div_d    = {1'b0, r_x[AW-1:0]};
    assign div_ge   = (div_t >= div_d);
    assign div_diff = div_t - div_d;

    assign mul_sum  = {1'b0, r_prod[AW+PW-1:PW]} + (r_prod[0] ? {1'b0, r_q} : '0);
    assign prod_ovf = |r_prod[AW+PW-1:AW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= AW'(1);
            r_ovf <= 1'b0;
        end else if (i_cmd.load && i_restart) begin
            r_acc <= AW'(1);
            r_ovf <= 1'b0;
        end else if (i_cmd.commit) begin
            case (i_cmd.kind)
                hla_pkg::K_ZERO: begin
                    r_acc <= r_acc;
                end
                hla_pkg::K_SAT: begin
                    r_acc <= '1;
                end
                default: begin
                    r_acc <= prod_ovf ? '1 : r_prod[AW-1:0];
                    r_ovf <= prod_ovf;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= GW'(a_eff);
            r_y    <= GW'(i_period);
            r_ash  <= a_eff;
            r_prod <= (AW+PW)'(i_period);
        end else if (i_cmd.gcd_step) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_ash <= n_ash;
        end else if (i_cmd.mul_step) begin
            r_prod <= {mul_sum, r_prod[PW-1:1]};
        end

        if (i_cmd.div_load) begin
            r_q   <= r_ash;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[AW-1:0] : div_t[AW-1:0];
            r_q   <= {r_q[AW-2:0], div_ge};
        end

        if (i_cmd.commit) begin
            case (i_cmd.kind)
                hla_pkg::K_ZERO: begin
                    r_out_lcm  <= r_acc;
                    r_out_ovf  <= r_ovf;
                    r_out_zero <= 1'b1;
                end
                hla_pkg::K_SAT: begin
                    r_out_lcm  <= '1;
                    r_out_ovf  <= 1'b1;
                    r_out_zero <= 1'b0;
                end
                default: begin
                    r_out_lcm  <= prod_ovf ? '1 : r_prod[AW-1:0];
                    r_out_ovf  <= prod_ovf;
                    r_out_zero <= 1'b0;
                end
            endcase
        end
    end

    assign o_running_lcm = r_out_lcm;
    assign o_overflowed  = r_out_ovf;
    assign o_zero_period = r_out_zero;

endmodule

FILE: sv/hla_ctrl.sv
// Controller: sequences gcd, divide, multiply and write-back for one transaction.
module hla_ctrl #(
    parameter int PW = hla_pkg::PERIOD_WIDTH_DEF,
    parameter int AW = hla_pkg::ACC_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  hla_pkg::t_sts i_sts,
    output hla_pkg::t_cmd o_cmd
);

    localparam int GW = (AW > PW) ? AW : PW;
    localparam int CW = $clog2(GW);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    hla_pkg::t_kind r_kind;
    hla_pkg::t_kind n_kind;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    logic           r_out_valid;
    logic           n_out_valid;
    logic           out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.zero_in) begin
                        n_kind  = hla_pkg::K_ZERO;
                        n_state = S_WB;
                    end else if (i_sts.sat_in) begin
                        n_kind  = hla_pkg::K_SAT;
                        n_state = S_WB;
                    end else begin
                        n_kind  = hla_pkg::K_MUL;
                        n_state = S_GCD;
                    end
                end
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_load = 1'b1;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CW'(AW-1)) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == CW'(PW-1)) begin
                    n_cnt   = '0;
                    n_state = S_WB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WB: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= hla_pkg::K_ZERO;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    a_valid_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_WB))
        else $error("result appeared without a write-back");

    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CW'(AW-1)))
        else $error("divider count out of range");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state != S_IDLE))
        else $error("accepted transaction not started");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

FILE: sv/hyperperiod_lcm_accumulator_core.sv
// Top level: running LCM of task periods (hyperperiod), controller plus datapath.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------------
//  input    | in        | i_valid / o_stall  | i_period, i_restart
//  result   | out       | o_valid / i_stall  | o_running_lcm, o_overflowed, o_zero_period
//
// One transaction at a time. A zero period, or one arriving after overflow, goes from accept
// straight to write-back. Otherwise: accept, binary gcd (one bit removed per cycle), restoring
// divide, shift-add multiply and write-back.
// Reset (synchronous, active low) sets the running value to 1 and clears the overflow flag.
// The result sits in an output register; a new transaction is taken while it is stalled,
// and write-back waits only if the previous result has still not been taken.
module hyperperiod_lcm_accumulator_core #(
    parameter int PERIOD_WIDTH = hla_pkg::PERIOD_WIDTH_DEF,
    parameter int ACC_WIDTH    = hla_pkg::ACC_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [PERIOD_WIDTH-1:0] i_period,
    input  logic                    i_restart,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ACC_WIDTH-1:0]    o_running_lcm,
    output logic                    o_overflowed,
    output logic                    o_zero_period
);

    hla_pkg::t_cmd cmd;
    hla_pkg::t_sts sts;

    // Sequencer: decides the path per transaction and counts divide/multiply steps
    hla_ctrl #(
        .PW (PERIOD_WIDTH),
        .AW (ACC_WIDTH)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Arithmetic: lcm = (a / gcd(a,p)) * p, saturating when the product exceeds ACC_WIDTH
    hla_datapath #(
        .PW (PERIOD_WIDTH),
        .AW (ACC_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_period      (i_period),
        .i_restart     (i_restart),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_running_lcm (o_running_lcm),
        .o_overflowed  (o_overflowed),
        .o_zero_period (o_zero_period)
    );

endmodule
